FILE: src/kle_pkg.sv
package kle_pkg;

    localparam int KIND_W     = 2;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 4;
    localparam int CODE_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 4;
    localparam int IN_DATA_W  = 16;

    localparam int DEFAULT_ROWS    = 8;
    localparam int DEFAULT_COLUMNS = 16;

    localparam logic [ROW_W-1:0] FN_ROW_RESET    = 3'd4;
    localparam logic [COL_W-1:0] FN_COLUMN_RESET = 4'd1;
    localparam logic             FN_ENABLE_RESET = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_MAIN_MAP = 2'd1,
        KIND_FN_MAP   = 2'd2
    } kind_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_FN_KEY_ROW    = 2'd0,
        CFG_FN_KEY_COLUMN = 2'd1,
        CFG_FN_KEY_ENABLE = 2'd2
    } cfg_index_t;

    typedef enum logic {
        EV_PRESS   = 1'b0,
        EV_RELEASE = 1'b1
    } event_kind_t;

    // per-item control from the scan front to the lookup stage
    typedef struct packed {
        logic sample;
        logic press;
        logic fn_hit;
    } scan_ctl_t;

endpackage

FILE: src/kle_ram.sv
module kle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/kle_scan_front.sv
module kle_scan_front #(
    parameter int ROWS    = 8,
    parameter int COLUMNS = 16,
    parameter int KEY_W   = 7
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [kle_pkg::KIND_W-1:0]        kind,
    input  logic [kle_pkg::ROW_W-1:0]         key_row,
    input  logic [kle_pkg::COL_W-1:0]         key_column,
    input  logic                              level,
    input  logic                              layer_wr,
    input  logic                              layer_value,
    input  logic                              cfg_wr_en,
    input  logic [kle_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [kle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output logic [KEY_W-1:0]                  key_idx,
    output logic                              main_wr_en,
    output logic                              fn_wr_en,
    output kle_pkg::scan_ctl_t                ctl,
    output logic                              fn_active
);
    import kle_pkg::*;

    logic [ROW_W-1:0] fn_row_reg;
    logic [COL_W-1:0] fn_col_reg;
    logic             fn_en_reg;
    logic             fn_active_reg;
    logic             fn_active_next;
    logic             in_range;
    logic             fn_hit;

    assign in_range = (32'(key_row) < ROWS) && (32'(key_column) < COLUMNS);
    assign key_idx  = KEY_W'(32'(key_row) * COLUMNS + 32'(key_column));
    assign fn_hit   = fn_en_reg && (key_row == fn_row_reg) && (key_column == fn_col_reg);

    assign main_wr_en = accept && in_range && (kind == KIND_MAIN_MAP);
    assign fn_wr_en   = accept && in_range && (kind == KIND_FN_MAP);

    assign ctl.sample = accept && in_range && (kind == KIND_SAMPLE);
    assign ctl.press  = level;
    assign ctl.fn_hit = fn_hit;
    assign fn_active  = fn_active_reg;

    // layer follows the function key edge resolved in the lookup stage; disabling the function key clears it
    always_comb begin
        fn_active_next = fn_active_reg;
        if (layer_wr) begin
            fn_active_next = layer_value;
        end
        if (cfg_wr_en && (cfg_addr == CFG_FN_KEY_ENABLE) && !cfg_wdata[0]) begin
            fn_active_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fn_active_reg <= 1'b0;
            fn_row_reg    <= FN_ROW_RESET;
            fn_col_reg    <= FN_COLUMN_RESET;
            fn_en_reg     <= FN_ENABLE_RESET;
        end else begin
            fn_active_reg <= fn_active_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_FN_KEY_ROW:    fn_row_reg <= cfg_wdata[ROW_W-1:0];
                    CFG_FN_KEY_COLUMN: fn_col_reg <= cfg_wdata[COL_W-1:0];
                    CFG_FN_KEY_ENABLE: fn_en_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: src/keymatrix_layer_event_encoder.sv
// a press or release result leaves on m_ from the output register after the lookup stage;
// throughput: one item per cycle unless m_ stalls or clearing runs; key state, keymaps and
// held codes sit in registered-read memories, a key state written by the lookup stage is
// forwarded to the next item of that key; reset (aresetn low, synchronous): main layer,
// function key at row 4 column 1 enabled, then a clearing pass over all ROWS*COLUMNS keys
// (128 by default) with s_tready low marks all keys up; keymaps are undefined until loaded
module keymatrix_layer_event_encoder #(
    parameter int ROWS    = kle_pkg::DEFAULT_ROWS,
    parameter int COLUMNS = kle_pkg::DEFAULT_COLUMNS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [kle_pkg::IN_DATA_W-1:0]     s_tdata,   // key_row, key_column, level, code
    input  logic [kle_pkg::KIND_W-1:0]        s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [kle_pkg::CODE_W-1:0]        m_tdata,   // keycode
    output logic                              m_tuser,   // event_kind
    input  logic                              cfg_wr_en,
    input  logic [kle_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [kle_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import kle_pkg::*;

    localparam int KEYS    = ROWS * COLUMNS;
    localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int STATE_W = CODE_W + 1;

    logic               s_fire;
    logic [KEY_W-1:0]   key_idx;
    logic               main_wr_en;
    logic               fn_wr_en;
    scan_ctl_t          ctl;
    logic               fn_active;
    logic [CODE_W-1:0]  main_rd;
    logic [CODE_W-1:0]  fn_rd;
    logic [STATE_W-1:0] state_rd;

    logic               clr_active_reg;
    logic [KEY_W-1:0]   clr_idx_reg;

    logic               st1_valid_reg;
    logic               st1_press_reg;
    logic               st1_fn_hit_reg;
    logic [KEY_W-1:0]   st1_key_reg;
    logic               st1_fwd_reg;
    logic [STATE_W-1:0] st1_fwd_state_reg;

    logic               m_valid_reg;
    logic [CODE_W-1:0]  m_code_reg;
    logic               m_kind_reg;

    logic [STATE_W-1:0] state_cur;
    logic [CODE_W-1:0]  held_cur;
    logic               key_edge;
    logic [CODE_W-1:0]  look_code;
    logic [CODE_W-1:0]  out_code;
    logic               out_free;
    logic               st1_fire;
    logic               state_wr_en;
    logic [STATE_W-1:0] state_wdata;
    logic               layer_wr;
    logic               mem_wr_en;
    logic [KEY_W-1:0]   mem_wr_addr;
    logic [STATE_W-1:0] mem_wr_data;

    assign s_fire = s_tvalid && s_tready;

    kle_scan_front #(
        .ROWS    (ROWS),
        .COLUMNS (COLUMNS),
        .KEY_W   (KEY_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (s_fire),
        .kind        (s_tuser),
        .key_row     (s_tdata[2:0]),
        .key_column  (s_tdata[6:3]),
        .level       (s_tdata[7]),
        .layer_wr    (layer_wr),
        .layer_value (st1_press_reg),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .key_idx     (key_idx),
        .main_wr_en  (main_wr_en),
        .fn_wr_en    (fn_wr_en),
        .ctl         (ctl),
        .fn_active   (fn_active)
    );

    kle_ram #(.WIDTH(CODE_W), .DEPTH(KEYS), .ADDR_W(KEY_W)) u_main_map (
        .aclk    (aclk),
        .wr_en   (main_wr_en),
        .wr_addr (key_idx),
        .wr_data (s_tdata[15:8]),
        .rd_en   (s_fire),
        .rd_addr (key_idx),
        .rd_data (main_rd)
    );

    kle_ram #(.WIDTH(CODE_W), .DEPTH(KEYS), .ADDR_W(KEY_W)) u_fn_map (
        .aclk    (aclk),
        .wr_en   (fn_wr_en),
        .wr_addr (key_idx),
        .wr_data (s_tdata[15:8]),
        .rd_en   (s_fire),
        .rd_addr (key_idx),
        .rd_data (fn_rd)
    );

    // per key: down bit above the held code
    kle_ram #(.WIDTH(STATE_W), .DEPTH(KEYS), .ADDR_W(KEY_W)) u_key_state (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (s_fire),
        .rd_addr (key_idx),
        .rd_data (state_rd)
    );

    assign state_cur   = st1_fwd_reg ? st1_fwd_state_reg : state_rd;
    assign held_cur    = state_cur[CODE_W-1:0];
    assign key_edge    = st1_valid_reg && (st1_press_reg != state_cur[CODE_W]);
    // function layer wins only where its entry is set
    assign look_code   = (fn_active && (fn_rd != '0)) ? fn_rd : main_rd;
    assign out_code    = st1_press_reg ? look_code : held_cur;
    assign out_free    = !m_valid_reg || m_tready;
    assign st1_fire    = st1_valid_reg && out_free;
    assign state_wr_en = st1_fire && key_edge;
    assign state_wdata = {st1_press_reg, out_code};
    assign layer_wr    = state_wr_en && st1_fn_hit_reg;
    assign mem_wr_en   = clr_active_reg || state_wr_en;
    assign mem_wr_addr = clr_active_reg ? clr_idx_reg : st1_key_reg;
    assign mem_wr_data = clr_active_reg ? '0 : state_wdata;
    assign s_tready    = !clr_active_reg && (!st1_valid_reg || st1_fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            st1_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (clr_active_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == KEY_W'(KEYS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s_fire) begin
                st1_valid_reg <= ctl.sample;
            end else if (st1_fire) begin
                st1_valid_reg <= 1'b0;
            end
            if (out_free) begin
                m_valid_reg <= key_edge && (out_code != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_press_reg     <= ctl.press;
            st1_fn_hit_reg    <= ctl.fn_hit;
            st1_key_reg       <= key_idx;
            // key state being written this edge is not yet in the memory read
            st1_fwd_reg       <= state_wr_en && (st1_key_reg == key_idx);
            st1_fwd_state_reg <= state_wdata;
        end
        if (st1_fire) begin
            m_code_reg <= out_code;
            m_kind_reg <= st1_press_reg ? EV_PRESS : EV_RELEASE;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_code_reg;
    assign m_tuser  = m_kind_reg;

    a_code_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata != '0))
        else $error("result item with zero keycode");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && m_tvalid && !m_tready) |-> !s_tready)
        else $error("item accepted while lookup stage is blocked");

    a_enable_clears_layer: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wr_en && (cfg_addr == CFG_FN_KEY_ENABLE) && !cfg_wdata[0]) |=> !fn_active)
        else $error("function layer still active after disable");

endmodule
